// ----- design/tsrl_pkg.sv -----
// Shared types and constants of the timestamped sample ring logger.
package tsrl_pkg;

   // Fixed field widths.
   localparam int TIME_W   = 32;
   localparam int VALUE_W  = 12;
   localparam int PERIOD_W = 17;
   localparam int NEXT_W   = TIME_W + 1;

   // Sample period after reset, in seconds (five minutes).
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(300);

   // Transaction kinds on the request channel.
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_ACK  = 1'b1
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request transaction
      logic exec;   // update schedule, ring pointers and store
   } ctrl_cmd_type;

endpackage

// ----- design/tsrl_ctrl.sv -----
// Controller state machine of the timestamped sample ring logger.
module tsrl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tsrl_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: take a request, do the update, then hold the response.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake and datapath commands.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC);

endmodule

// ----- design/tsrl_datapath.sv -----
// Datapath of the timestamped sample ring logger: schedule, ring pointers and sample store.
module tsrl_datapath #(
   parameter int DEPTH = 256,
   parameter int PTR_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tsrl_pkg::ctrl_cmd_type               cmd,
   input  logic                                 csr_wr_en,
   input  logic [tsrl_pkg::PERIOD_W-1:0]        csr_wr_data,
   input  logic                                 req_opcode,
   input  logic [tsrl_pkg::TIME_W-1:0]          req_current_time,
   input  logic [tsrl_pkg::VALUE_W-1:0]         req_sensor_value,
   output logic                                 rsp_head_valid,
   output logic [tsrl_pkg::TIME_W-1:0]          rsp_head_timestamp,
   output logic [tsrl_pkg::VALUE_W-1:0]         rsp_head_value,
   output logic [CNT_W-1:0]                     rsp_occupancy,
   output logic                                 rsp_sample_taken,
   output logic                                 rsp_oldest_dropped,
   output logic [tsrl_pkg::TIME_W-1:0]          rsp_seconds_to_next
);

   localparam int ENTRY_W = tsrl_pkg::TIME_W + tsrl_pkg::VALUE_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   // Configuration and control state.
   logic [tsrl_pkg::PERIOD_W-1:0] period_ff;
   logic [tsrl_pkg::NEXT_W-1:0]   next_ff, next_in;
   logic [PTR_W-1:0]              wp_ff, wp_in;
   logic [PTR_W-1:0]              rp_ff, rp_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   // Captured transaction and precomputed schedule candidates.
   tsrl_pkg::opcode_type          op_ff;
   logic [tsrl_pkg::TIME_W-1:0]   now_ff;
   logic [tsrl_pkg::VALUE_W-1:0]  value_ff;
   logic [tsrl_pkg::NEXT_W-1:0]   adv_ff;
   logic [tsrl_pkg::NEXT_W-1:0]   restart_ff;

   // Result registers.
   logic                          taken_ff;
   logic                          dropped_ff;
   logic [ENTRY_W-1:0]            rd_ff;
   logic                          fwd_ff;
   logic [ENTRY_W-1:0]            fwd_data_ff;

   logic [ENTRY_W-1:0]            mem [DEPTH];

   logic [tsrl_pkg::NEXT_W-1:0]   now_ext;
   logic                          due;
   logic                          ack_do;
   logic                          full;
   logic                          rp_adv;
   logic [ENTRY_W-1:0]            wr_data;
   logic [tsrl_pkg::NEXT_W-1:0]   gap_full;
   logic [ENTRY_W-1:0]            head_entry;

   // Sample period register; write it only while the block is idle: the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tsrl_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // Capture the request; both schedule candidates are formed here so that the
   // update cycle needs only compares and selection.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= tsrl_pkg::opcode_type'(req_opcode);
         now_ff     <= req_current_time;
         value_ff   <= req_sensor_value;
         adv_ff     <= next_ff + tsrl_pkg::NEXT_W'(period_ff);
         restart_ff <= tsrl_pkg::NEXT_W'(req_current_time) + tsrl_pkg::NEXT_W'(period_ff);
      end
   end

   // Update decisions for the captured transaction.
   always_comb begin
      now_ext  = tsrl_pkg::NEXT_W'(now_ff);
      due      = (op_ff == tsrl_pkg::OP_TICK) && (next_ff <= now_ext);
      ack_do   = (op_ff == tsrl_pkg::OP_ACK) && (count_ff != '0);
      full     = (count_ff == CNT_FULL);
      rp_adv   = (due && full) || ack_do;
      wr_data  = {now_ff, value_ff};

      next_in  = next_ff;
      if (due) begin
         next_in = (adv_ff <= now_ext) ? restart_ff : adv_ff;
      end

      rp_in = rp_ff;
      if (rp_adv) begin
         rp_in = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
      end

      wp_in = wp_ff;
      if (due) begin
         wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
      end

      count_in = count_ff;
      if (due && !full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ack_do) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff  <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         next_ff  <= next_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // Sample store: write the new sample and read the new head in the same cycle.
   // A head that is the entry being written comes from the forwarding register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (due) begin
            mem[wp_ff] <= wr_data;
         end
         rd_ff       <= mem[rp_in];
         fwd_ff      <= due && (wp_ff == rp_in);
         fwd_data_ff <= wr_data;
         taken_ff    <= due;
         dropped_ff  <= due && full;
      end
   end

   // Response fields from the updated state.
   always_comb begin
      head_entry = fwd_ff ? fwd_data_ff : rd_ff;
      gap_full   = next_ff - tsrl_pkg::NEXT_W'(now_ff);

      rsp_head_valid     = (count_ff != '0);
      rsp_head_timestamp = '0;
      rsp_head_value     = '0;
      if (count_ff != '0) begin
         rsp_head_timestamp = head_entry[ENTRY_W-1:tsrl_pkg::VALUE_W];
         rsp_head_value     = head_entry[tsrl_pkg::VALUE_W-1:0];
      end
      rsp_occupancy      = count_ff;
      rsp_sample_taken   = taken_ff;
      rsp_oldest_dropped = dropped_ff;

      if (next_ff <= tsrl_pkg::NEXT_W'(now_ff)) begin
         rsp_seconds_to_next = '0;
      end else if (gap_full[tsrl_pkg::NEXT_W-1]) begin
         rsp_seconds_to_next = '1;
      end else begin
         rsp_seconds_to_next = gap_full[tsrl_pkg::TIME_W-1:0];
      end
   end

endmodule

// ----- design/timestamped_sample_ring_logger.sv -----
// Top level of the timestamped sample ring logger.
//
//   Channel   Ports                       Direction  Carries
//   request   req_valid / req_ready       in         opcode, current time, sensor reading
//   response  rsp_valid / rsp_ready       out        head entry, occupancy, flags, time to next
//   csr       csr_wr_en / csr_wr_data     in         sample period, written at once
//
// Each transaction passes through the idle state, whose closing edge accepts and captures it,
// the update state, which writes the new sample and reads the new head of the store in the
// same cycle, and the response state, in which the response is valid. A stalled response
// holds the block; the next request is taken in the cycle after the response is accepted.
// Reset empties the ring, sets the period to 300 and makes the first tick sample; the store
// needs no clearing pass.
module timestamped_sample_ring_logger #(
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic [tsrl_pkg::TIME_W-1:0]           req_current_time,
   input  logic [tsrl_pkg::VALUE_W-1:0]          req_sensor_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_head_valid,
   output logic [tsrl_pkg::TIME_W-1:0]           rsp_head_timestamp,
   output logic [tsrl_pkg::VALUE_W-1:0]          rsp_head_value,
   output logic [$clog2(DEPTH + 1)-1:0]          rsp_occupancy,
   output logic                                  rsp_sample_taken,
   output logic                                  rsp_oldest_dropped,
   output logic [tsrl_pkg::TIME_W-1:0]           rsp_seconds_to_next,
   input  logic                                  csr_wr_en,
   input  logic [tsrl_pkg::PERIOD_W-1:0]         csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsrl_pkg::ctrl_cmd_type cmd;

   tsrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tsrl_datapath #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_opcode          (req_opcode),
      .req_current_time    (req_current_time),
      .req_sensor_value    (req_sensor_value),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_timestamp  (rsp_head_timestamp),
      .rsp_head_value      (rsp_head_value),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_sample_taken    (rsp_sample_taken),
      .rsp_oldest_dropped  (rsp_oldest_dropped),
      .rsp_seconds_to_next (rsp_seconds_to_next)
   );

endmodule
